// File: hw/rtl/smm_pkg.sv
package smm_pkg;

  localparam int unsigned DIM     = 16;
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned IDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned DEPTH   = DIM * DIM;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ACC_W   = PROD_W + 1 + IDX_W;

  typedef enum logic [1:0] {
    KIND_WR_A  = 2'd0,
    KIND_WR_B  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  function automatic logic [ADDR_W-1:0] lin_addr(input logic [ADDR_W-1:0] r,
                                                 input logic [ADDR_W-1:0] c);
    logic [2*ADDR_W-1:0] full;
    full = r * ADDR_W'(DIM) + c;
    return full[ADDR_W-1:0];
  endfunction

endpackage

// File: hw/rtl/smm_store.sv
module smm_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [smm_pkg::ADDR_W-1:0]  waddr_i,
  input  logic [smm_pkg::ELEM_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [smm_pkg::ADDR_W-1:0]  raddr_i,
  output logic [smm_pkg::ELEM_W-1:0]  rdata_o
);
  import smm_pkg::*;

  logic [ELEM_W-1:0] mem_q [DEPTH];
  logic [ELEM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/smm_mac.sv
module smm_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  smm_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [smm_pkg::ELEM_W-1:0]  a_i,
  input  logic signed [smm_pkg::ELEM_W-1:0]  b_i,
  output logic                               busy_o,
  output logic        [smm_pkg::PROD_W-1:0]  result_o,
  output logic                               sat_o
);
  import smm_pkg::*;

  logic                     rd_vld_q;
  logic                     prod_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctrl_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= a_i * b_i;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // sum fits when all bits above the result's sign bit copy it
  assign fits = (&acc_q[ACC_W-1:PROD_W-1]) || !(|acc_q[ACC_W-1:PROD_W-1]);

  always_comb begin
    if (fits) begin
      result_o = acc_q[PROD_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      result_o = {1'b1, {(PROD_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(PROD_W-1){1'b1}}};
    end
  end

  assign sat_o  = !fits;
  assign busy_o = rd_vld_q || prod_vld_q;

endmodule

// File: hw/rtl/smm_ctrl.sv
module smm_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [smm_pkg::ROW_W-1:0]   row_i,
  input  logic [smm_pkg::ROW_W-1:0]   col_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [smm_pkg::ROW_W-1:0]   out_row_o,
  output logic [smm_pkg::ROW_W-1:0]   out_col_o,
  output logic                        we_a_o,
  output logic                        we_b_o,
  output logic [smm_pkg::ADDR_W-1:0]  waddr_o,
  output logic                        re_o,
  output logic [smm_pkg::ADDR_W-1:0]  ra_addr_o,
  output logic [smm_pkg::ADDR_W-1:0]  rb_addr_o,
  output smm_pkg::mac_ctrl_t          mac_o,
  input  logic                        mac_busy_i
);
  import smm_pkg::*;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  col_q, col_d;
  logic              in_range;
  logic              last_k;

  assign in_range = (int'(row_i) < DIM) && (int'(col_i) < DIM);
  assign last_k   = (int'(k_q) == DIM - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    row_d     = row_q;
    col_d     = col_q;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    we_a_o    = 1'b0;
    we_b_o    = 1'b0;
    re_o      = 1'b0;
    mac_o     = '0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          case (kind_e'(kind_i))
            KIND_WR_A: begin
              we_a_o = in_range;
            end
            KIND_WR_B: begin
              we_b_o = in_range;
            end
            KIND_QUERY: begin
              row_d       = row_i;
              col_d       = col_i;
              k_d         = '0;
              mac_o.clear = 1'b1;
              state_d     = in_range ? ST_ISSUE : ST_OUT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ISSUE: begin
        re_o        = 1'b1;
        mac_o.issue = 1'b1;
        k_d         = k_q + 1'b1;
        if (last_k) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy_i) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign waddr_o   = lin_addr(ADDR_W'(row_i), ADDR_W'(col_i));
  assign ra_addr_o = lin_addr(ADDR_W'(row_q), ADDR_W'(k_q));
  assign rb_addr_o = lin_addr(ADDR_W'(k_q), ADDR_W'(col_q));
  assign out_row_o = row_q;
  assign out_col_o = col_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(re_o && (we_a_o || we_b_o)))
    else $error("store read and write in the same cycle");

  a_idle_mac_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mac_busy_i)
    else $error("mac pipeline busy while idle");

  a_issue_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE && last_k) |=> (state_q == ST_DRAIN && mac_busy_i))
    else $error("last product not in flight after issue");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_ready_i) |=> !m_valid_o)
    else $error("result delivered twice");

endmodule

// File: hw/rtl/square_matrix_multiply.sv
// Dense DIM x DIM matrix multiply (DIM = 16) over signed Q16.16 elements. Each input
// transaction either writes one element of A or B (kind 0 or 1, no result) or
// queries one element of C (kind 2), which returns the exact dot product of A's row and
// B's column as saturated signed Q32.32 with a saturation flag in tuser. A query is
// computed by one 32x32 multiplier and one read port per matrix store doing one
// multiply-accumulate per cycle; s_axis_tready stays low until the result transaction
// completes. Elements must be written before they are read; kind 3 is accepted and
// dropped.
module square_matrix_multiply (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row[3:0], col[7:4], element[39:8]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // product[63:0], out_row[67:64], out_col[71:68]
  output logic        m_axis_tuser   // saturated[0]
);
  import smm_pkg::*;

  logic [ROW_W-1:0]         row, col, out_row, out_col;
  logic [ELEM_W-1:0]        element;
  logic                     we_a, we_b, re;
  logic [ADDR_W-1:0]        waddr, ra_addr, rb_addr;
  logic [ELEM_W-1:0]        a_data, b_data;
  mac_ctrl_t                mac_ctrl;
  logic                     mac_busy;
  logic [PROD_W-1:0]        product;
  logic                     sat;

  assign row     = s_axis_tdata[3:0];
  assign col     = s_axis_tdata[7:4];
  assign element = s_axis_tdata[39:8];

  smm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .kind_i     (s_axis_tuser),
    .row_i      (row),
    .col_i      (col),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .out_row_o  (out_row),
    .out_col_o  (out_col),
    .we_a_o     (we_a),
    .we_b_o     (we_b),
    .waddr_o    (waddr),
    .re_o       (re),
    .ra_addr_o  (ra_addr),
    .rb_addr_o  (rb_addr),
    .mac_o      (mac_ctrl),
    .mac_busy_i (mac_busy)
  );

  smm_store u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (element),
    .re_i    (re),
    .raddr_i (ra_addr),
    .rdata_o (a_data)
  );

  smm_store u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (element),
    .re_i    (re),
    .raddr_i (rb_addr),
    .rdata_o (b_data)
  );

  smm_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_i      (a_data),
    .b_i      (b_data),
    .busy_o   (mac_busy),
    .result_o (product),
    .sat_o    (sat)
  );

  assign m_axis_tdata = {out_col, out_row, product};
  assign m_axis_tuser = sat;

endmodule
